// ===== rtl/tmc_pkg.sv =====
`default_nettype none

package tmc_pkg;

  // Configuration port geometry.
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_PREHEAT  = 2'd0;
  localparam logic [1:0] REG_FIX_LOST = 2'd1;
  localparam logic [1:0] REG_START_TN = 2'd2;

  // Register reset values.
  localparam logic [23:0] PREHEAT_RESET  = 24'd60000;
  localparam logic [23:0] FIX_LOST_RESET = 24'd30000;
  localparam logic [15:0] START_TN_RESET = 16'd0;

  // Battery scaling constants.
  localparam logic [9:0] BAT_ZERO = 10'd532;
  localparam logic [6:0] BAT_FULL = 7'd100;

  // Operating modes; the code also selects the LED color.
  typedef enum logic [1:0] {
    MODE_SLEEP = 2'd0,
    MODE_NOFIX = 2'd1,
    MODE_TRACK = 2'd2,
    MODE_LOST  = 2'd3
  } mode_t;

  // Decoded switch positions.
  typedef enum logic [1:0] {
    POS_SLEEP = 2'd0,
    POS_LIGHT = 2'd1,
    POS_TRACK = 2'd2,
    POS_NONE  = 2'd3
  } pos_t;

  // Raw switch pin codes {pin_two, pin_one}.
  localparam logic [1:0] PIN_HOLD  = 2'd0;
  localparam logic [1:0] PIN_TRACK = 2'd1;
  localparam logic [1:0] PIN_LIGHT = 2'd2;
  localparam logic [1:0] PIN_SLEEP = 2'd3;

  typedef struct packed {
    logic        pin_one;
    logic        pin_two;
    logic        gps_valid;
    logic [31:0] now_ms;
    logic [9:0]  battery_adc;
  } upd_t;

  typedef struct packed {
    logic [1:0]  mode_now;
    logic [1:0]  switch_position;
    logic        switch_changed;
    logic        lamp_on;
    logic [1:0]  led_colour;
    logic        wake_strobe;
    logic        sleep_strobe;
    logic        new_track_strobe;
    logic [15:0] track_number;
    logic [6:0]  battery_percent;
  } res_t;

  // Register contents handed to the mode core.
  typedef struct packed {
    logic [23:0] preheat_ms;
    logic [23:0] fix_lost_limit_ms;
    logic [15:0] start_track_number;
    logic        track_load;
  } cfg_t;

  // Mode core outputs for one transaction.
  typedef struct packed {
    logic [1:0]  mode_now;
    logic [1:0]  switch_position;
    logic        switch_changed;
    logic        lamp_on;
    logic        wake_strobe;
    logic        sleep_strobe;
    logic        new_track_strobe;
    logic [15:0] track_number;
  } mode_status_t;

endpackage

`default_nettype wire

// ===== rtl/tmc_cfg_regs.sv =====
`default_nettype none

module tmc_cfg_regs
  import tmc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  logic [23:0] preheat_ms;
  logic [23:0] fix_lost_limit_ms;
  logic [15:0] start_track_number;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // Register writes in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      preheat_ms         <= PREHEAT_RESET;
      fix_lost_limit_ms  <= FIX_LOST_RESET;
      start_track_number <= START_TN_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PREHEAT:  preheat_ms         <= pwdata[23:0];
        REG_FIX_LOST: fix_lost_limit_ms  <= pwdata[23:0];
        REG_START_TN: start_track_number <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    unique case (reg_idx)
      REG_PREHEAT:  prdata = {8'd0, preheat_ms};
      REG_FIX_LOST: prdata = {8'd0, fix_lost_limit_ms};
      REG_START_TN: prdata = {16'd0, start_track_number};
      default:      prdata = '0;
    endcase
  end

  // A write of the start number also loads the track counter.
  always_comb begin
    cfg.preheat_ms         = preheat_ms;
    cfg.fix_lost_limit_ms  = fix_lost_limit_ms;
    cfg.start_track_number = pwdata[15:0];
    cfg.track_load         = wr_en && (reg_idx == REG_START_TN);
  end

endmodule

`default_nettype wire

// ===== rtl/tmc_mode_core.sv =====
`default_nettype none

module tmc_mode_core
  import tmc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   advance,
  input  upd_t        upd,
  input  cfg_t        cfg,
  output mode_status_t status
);

  mode_t       mode, mode_next;
  pos_t        switch_pos, switch_pos_next;
  logic [31:0] time_stamp, time_stamp_next;
  logic [15:0] track_count, track_count_next;
  logic [31:0] elapsed;
  logic        changed;
  logic        go_sleep;
  logic        wake;
  logic        sleep;
  logic        new_track;

  // State registers; they move when a transaction leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_SLEEP;
      switch_pos  <= POS_SLEEP;
      time_stamp  <= '0;
      track_count <= START_TN_RESET;
    end else begin
      if (cfg.track_load) begin
        track_count <= cfg.start_track_number;
      end else if (advance) begin
        track_count <= track_count_next;
      end
      if (advance) begin
        mode       <= mode_next;
        switch_pos <= switch_pos_next;
        time_stamp <= time_stamp_next;
      end
    end
  end

  // Switch decode; the all-low code keeps the previous position.
  always_comb begin
    unique case ({upd.pin_two, upd.pin_one})
      PIN_SLEEP: switch_pos_next = POS_SLEEP;
      PIN_LIGHT: switch_pos_next = POS_LIGHT;
      PIN_TRACK: switch_pos_next = POS_TRACK;
      default:   switch_pos_next = switch_pos;
    endcase
  end

  assign changed  = (switch_pos_next != switch_pos);
  assign go_sleep = changed && (switch_pos_next == POS_SLEEP);
  assign elapsed  = upd.now_ms - time_stamp;

  // Mode transitions; a move of the switch to sleep wins in every awake mode.
  always_comb begin
    mode_next        = mode;
    time_stamp_next  = time_stamp;
    track_count_next = track_count;
    wake             = 1'b0;
    sleep            = 1'b0;
    new_track        = 1'b0;
    unique case (mode)
      MODE_SLEEP: begin
        if (changed && (switch_pos_next != POS_SLEEP)) begin
          mode_next       = MODE_NOFIX;
          time_stamp_next = upd.now_ms;
          wake            = 1'b1;
        end
      end
      MODE_NOFIX: begin
        if (go_sleep) begin
          mode_next = MODE_SLEEP;
          sleep     = 1'b1;
        end else if (upd.gps_valid && (elapsed >= {8'd0, cfg.preheat_ms})) begin
          mode_next        = MODE_TRACK;
          track_count_next = track_count + 16'd1;
          new_track        = 1'b1;
        end
      end
      MODE_TRACK: begin
        if (go_sleep) begin
          mode_next = MODE_SLEEP;
          sleep     = 1'b1;
        end else if (!upd.gps_valid) begin
          mode_next       = MODE_LOST;
          time_stamp_next = upd.now_ms;
        end
      end
      default: begin
        if (go_sleep) begin
          mode_next = MODE_SLEEP;
          sleep     = 1'b1;
        end else if (upd.gps_valid) begin
          mode_next = MODE_TRACK;
        end else if (elapsed > {8'd0, cfg.fix_lost_limit_ms}) begin
          mode_next = MODE_NOFIX;
        end
      end
    endcase
  end

  // Status of this transaction, taken after the step.
  always_comb begin
    status.mode_now         = mode_next;
    status.switch_position  = switch_pos_next;
    status.switch_changed   = changed;
    status.lamp_on          = (mode_next != MODE_SLEEP) && (switch_pos_next == POS_LIGHT);
    status.wake_strobe      = wake;
    status.sleep_strobe     = sleep;
    status.new_track_strobe = new_track;
    status.track_number     = track_count_next;
  end

endmodule

`default_nettype wire

// ===== rtl/tmc_battery.sv =====
`default_nettype none

module tmc_battery
  import tmc_pkg::*;
(
  input  wire logic [9:0] adc,
  output logic      [6:0] percent
);

  // Percent is (adc - 532) * 5 / 6; from an offset of 120 on it is full.
  // Below that, x / 6 for x under 600 is exact as (x * 683) >> 12.
  logic [9:0]  offset;
  logic [9:0]  scaled;
  logic [19:0] prod;

  assign offset = adc - BAT_ZERO;
  assign scaled = {3'd0, offset[6:0]} * 10'd5;
  assign prod   = {10'd0, scaled} * 20'd683;

  always_comb begin
    priority if (adc <= BAT_ZERO) begin
      percent = '0;
    end else if (offset >= 10'd120) begin
      percent = BAT_FULL;
    end else begin
      percent = prod[18:12];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tracker_mode_controller_unit.sv =====
`default_nettype none

// Mode controller of a position tracker. Each update transaction (switch pins,
// GPS-fix flag, millisecond time, battery sample) yields exactly one result
// transaction with the mode after the update, the decoded switch, lamp and LED
// color, wake/sleep/new-track strobes, the track number and the battery percent.
// One update is accepted every clock cycle unless upd_stall is high; a result
// is presented once its update has passed the input register and then the
// result register, and a stall can hold it between the two. A stall on the
// result side holds the result register and then the input register.
// Registers sit on an APB-style port at byte addresses 0, 4 and 8: preheat
// time, fix-lost limit and start track number; writing the start number also
// loads the track counter. Write registers only while no update is in flight.
module tracker_mode_controller_unit
  import tmc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              upd_valid,
  output logic                   upd_stall,
  input  upd_t                   upd,
  output logic                   res_valid,
  input  wire logic              res_stall,
  output res_t                   res,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  cfg_t         cfg;
  mode_status_t status;
  upd_t         upd_q;
  logic         upd_q_valid;
  logic         res_open;
  logic         advance;
  logic [6:0]   percent;

  tmc_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tmc_mode_core u_mode_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .upd     (upd_q),
    .cfg     (cfg),
    .status  (status)
  );

  tmc_battery u_battery (
    .adc     (upd_q.battery_adc),
    .percent (percent)
  );

  // Flow control between the input and result registers.
  assign res_open  = !res_valid || !res_stall;
  assign advance   = upd_q_valid && res_open;
  assign upd_stall = upd_q_valid && !res_open;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      upd_q_valid <= 1'b0;
    end else if (!upd_stall) begin
      upd_q_valid <= upd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_valid && !upd_stall) begin
      upd_q <= upd;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_open) begin
      res_valid <= upd_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res.mode_now         <= status.mode_now;
      res.switch_position  <= status.switch_position;
      res.switch_changed   <= status.switch_changed;
      res.lamp_on          <= status.lamp_on;
      res.led_colour       <= status.mode_now;
      res.wake_strobe      <= status.wake_strobe;
      res.sleep_strobe     <= status.sleep_strobe;
      res.new_track_strobe <= status.new_track_strobe;
      res.track_number     <= status.track_number;
      res.battery_percent  <= percent;
    end
  end

  // A new track is only counted on entry into tracking.
  a_new_track_tracking: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.new_track_strobe |-> res.mode_now == MODE_TRACK)
    else $error("new track strobe outside tracking");

  // Entering sleep always leaves the block sleeping and never wakes at once.
  a_sleep_strobe: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.sleep_strobe |-> res.mode_now == MODE_SLEEP && !res.wake_strobe)
    else $error("sleep strobe with wrong mode");

  // The lamp never burns while sleeping.
  a_lamp_awake: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.lamp_on |-> res.mode_now != MODE_SLEEP)
    else $error("lamp on while sleeping");

  // Battery percent saturates at full.
  a_battery_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.battery_percent <= BAT_FULL)
    else $error("battery percent above full");

endmodule

`default_nettype wire

// ===== verif/tracker_mode_controller_unit_test.sv =====
`timescale 1ns / 1ps

module tracker_mode_controller_unit_test;
  import tmc_pkg::*;

  // Index with no register behind it; writes there must leave everything alone.
  localparam logic [1:0] REG_SPARE = 2'd3;

  // Battery scaling: percent = (adc - zero) * 10 / 12.
  localparam int unsigned BAT_SCALE_MUL = 10;
  localparam int unsigned BAT_SCALE_DIV = 12;

  localparam int unsigned PHASE_COUNT = 8;
  localparam int unsigned ITEMS_PER_PHASE = 120;
  localparam int unsigned REPORT_LIMIT = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic upd_valid = 1'b0;
  logic upd_stall;
  upd_t upd = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;

  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  tracker_mode_controller_unit dut (
    .clk(clk),
    .rst(rst),
    .upd_valid(upd_valid),
    .upd_stall(upd_stall),
    .upd(upd),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res(res),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #10 clk = ~clk;

  // Mirror of the controller state and its registers.
  mode_t mode_q;
  pos_t position_q;
  logic [31:0] stamp_q;
  logic [15:0] track_q;
  logic [23:0] preheat_q;
  logic [23:0] lost_limit_q;
  logic [15:0] start_track_q;

  upd_t pending_updates[$];
  res_t expected_results[$];
  res_t expected_head;
  int unsigned updates_queued = 0;
  int unsigned results_checked = 0;
  int unsigned error_count = 0;

  // Random stimulus shaping.
  logic [31:0] time_cursor = '0;
  logic gps_level = 1'b0;
  int unsigned step_max = 64;

  // Driver burst and gap bookkeeping; receiver stall pattern.
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_mode = 0;

  // Computes the result of one update and advances the mirrored state.
  function automatic res_t predict_mode_update(upd_t u);
    res_t r;
    pos_t old_position;
    logic [1:0] code;
    logic [31:0] elapsed;
    logic changed;
    logic go_sleep;
    logic wake;
    logic sleep;
    logic new_track;
    int unsigned scaled;

    code = {u.pin_two, u.pin_one};
    old_position = position_q;
    wake = 1'b0;
    sleep = 1'b0;
    new_track = 1'b0;

    // The hold code leaves the switch where it was.
    case (code)
      PIN_SLEEP: position_q = POS_SLEEP;
      PIN_LIGHT: position_q = POS_LIGHT;
      PIN_TRACK: position_q = POS_TRACK;
      default: position_q = position_q;
    endcase
    changed = (position_q != old_position);
    go_sleep = changed && (position_q == POS_SLEEP);
    elapsed = u.now_ms - stamp_q;

    // A move to the sleep position wins in every awake mode.
    case (mode_q)
      MODE_SLEEP: begin
        if (changed && position_q != POS_SLEEP) begin
          stamp_q = u.now_ms;
          mode_q = MODE_NOFIX;
          wake = 1'b1;
        end
      end
      MODE_NOFIX: begin
        if (go_sleep) begin
          mode_q = MODE_SLEEP;
          sleep = 1'b1;
        end else if (u.gps_valid && elapsed >= {8'd0, preheat_q}) begin
          track_q = track_q + 16'd1;
          new_track = 1'b1;
          mode_q = MODE_TRACK;
        end
      end
      MODE_TRACK: begin
        if (go_sleep) begin
          mode_q = MODE_SLEEP;
          sleep = 1'b1;
        end else if (!u.gps_valid) begin
          stamp_q = u.now_ms;
          mode_q = MODE_LOST;
        end
      end
      default: begin
        if (go_sleep) begin
          mode_q = MODE_SLEEP;
          sleep = 1'b1;
        end else if (u.gps_valid) begin
          mode_q = MODE_TRACK;
        end else if (elapsed > {8'd0, lost_limit_q}) begin
          mode_q = MODE_NOFIX;
        end
      end
    endcase

    // Battery percent, zero at or below the floor and saturated at full.
    if (u.battery_adc <= BAT_ZERO) begin
      scaled = 0;
    end else begin
      scaled = u.battery_adc;
      scaled = (scaled - BAT_ZERO) * BAT_SCALE_MUL / BAT_SCALE_DIV;
      if (scaled > BAT_FULL) scaled = BAT_FULL;
    end

    r.mode_now = mode_q;
    r.switch_position = position_q;
    r.switch_changed = changed;
    r.lamp_on = (mode_q != MODE_SLEEP) && (position_q == POS_LIGHT);
    r.led_colour = mode_q;
    r.wake_strobe = wake;
    r.sleep_strobe = sleep;
    r.new_track_strobe = new_track;
    r.track_number = track_q;
    r.battery_percent = scaled[6:0];
    return r;
  endfunction

  function automatic upd_t make_update(logic [1:0] code, logic gps, logic [31:0] now,
                                       logic [9:0] adc);
    upd_t u;
    u.pin_one = code[0];
    u.pin_two = code[1];
    u.gps_valid = gps;
    u.now_ms = now;
    u.battery_adc = adc;
    return u;
  endfunction

  // Mostly plausible operation: time moves forward, the fix comes and goes in
  // runs, and the switch rarely goes to sleep. A few items are pure noise.
  function automatic upd_t random_update();
    upd_t u;
    int unsigned pick;

    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      {u.pin_two, u.pin_one, u.gps_valid} = 3'($urandom);
      u.now_ms = $urandom;
      u.battery_adc = 10'($urandom);
      return u;
    end

    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      u.pin_one = 1'b0;
      u.pin_two = 1'b0;
    end else if (pick < 75) begin
      {u.pin_two, u.pin_one} = PIN_TRACK;
    end else if (pick < 95) begin
      {u.pin_two, u.pin_one} = PIN_LIGHT;
    end else begin
      {u.pin_two, u.pin_one} = PIN_SLEEP;
    end

    if ($urandom_range(0, 4) == 0) gps_level = ~gps_level;
    u.gps_valid = gps_level;

    if ($urandom_range(0, 49) == 0) time_cursor = $urandom;
    else time_cursor = time_cursor + $urandom_range(0, step_max);
    u.now_ms = time_cursor;

    if ($urandom_range(0, 4) == 0) u.battery_adc = 10'($urandom_range(520, 660));
    else u.battery_adc = 10'($urandom_range(0, 1023));
    return u;
  endfunction

  task automatic queue_update(upd_t u);
    pending_updates.push_back(u);
    updates_queued++;
  endtask

  // Register write: setup cycle, then access cycle; the mirror follows.
  task automatic write_register(logic [1:0] index, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (index)
      REG_PREHEAT: preheat_q = value[23:0];
      REG_FIX_LOST: lost_limit_q = value[23:0];
      REG_START_TN: begin
        start_track_q = value[15:0];
        track_q = value[15:0];
      end
      default: ;
    endcase
  endtask

  // Waits until every queued update has produced its checked result.
  task automatic wait_for_drain();
    while (results_checked != updates_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      error_count++;
      if (error_count <= REPORT_LIMIT)
        $display("mismatch in %s: expected %0h, got %0h", field, want, got);
    end
  endtask

  // Update driver: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      upd_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (upd_valid && !upd_stall) expected_results.push_back(predict_mode_update(upd));
      if (!upd_valid || !upd_stall) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          upd_valid <= 1'b0;
        end else if (pending_updates.size() != 0) begin
          upd <= pending_updates.pop_front();
          upd_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          upd_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each accepted result transaction and drives a stall
  // pattern whose character is redrawn when the low bits of the cycle counter wrap.
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      cycle_count <= cycle_count + 1;
      if (cycle_count[5:0] == 6'd0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: res_stall <= 1'b0;
        1: res_stall <= ($urandom_range(0, 3) == 0);
        2: res_stall <= ($urandom_range(0, 3) != 0);
        default: res_stall <= (cycle_count[2:0] < 3'd3);
      endcase

      if (res_valid && !res_stall) begin
        if (expected_results.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display("result transaction with no update pending: %p", res);
        end else begin
          expected_head = expected_results.pop_front();
          compare_field("mode_now", expected_head.mode_now, res.mode_now);
          compare_field("switch_position", expected_head.switch_position,
                        res.switch_position);
          compare_field("switch_changed", expected_head.switch_changed, res.switch_changed);
          compare_field("lamp_on", expected_head.lamp_on, res.lamp_on);
          compare_field("led_colour", expected_head.led_colour, res.led_colour);
          compare_field("wake_strobe", expected_head.wake_strobe, res.wake_strobe);
          compare_field("sleep_strobe", expected_head.sleep_strobe, res.sleep_strobe);
          compare_field("new_track_strobe", expected_head.new_track_strobe,
                        res.new_track_strobe);
          compare_field("track_number", expected_head.track_number, res.track_number);
          compare_field("battery_percent", expected_head.battery_percent,
                        res.battery_percent);
          results_checked++;
        end
      end
    end
  end

  // Stimulus: directed walk through the modes, then randomized phases.
  initial begin : stimulus
    int unsigned phase;
    int unsigned k;
    logic [31:0] preheat_value;
    logic [31:0] limit_value;
    logic [31:0] start_value;

    mode_q = MODE_SLEEP;
    position_q = POS_SLEEP;
    stamp_q = '0;
    preheat_q = PREHEAT_RESET;
    lost_limit_q = FIX_LOST_RESET;
    start_track_q = START_TN_RESET;
    track_q = START_TN_RESET;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: hold and sleep codes while asleep change nothing.
    queue_update(make_update(PIN_HOLD, 1'b1, 32'd0, 10'd0));
    queue_update(make_update(PIN_SLEEP, 1'b0, 32'd5, 10'd1023));
    // Wake, then the preheat boundary one short and exactly met.
    queue_update(make_update(PIN_LIGHT, 1'b0, 32'd1000, 10'd532));
    queue_update(make_update(PIN_HOLD, 1'b1, 32'd60999, 10'd533));
    queue_update(make_update(PIN_HOLD, 1'b1, 32'd61000, 10'd651));
    queue_update(make_update(PIN_TRACK, 1'b1, 32'd61001, 10'd652));
    // Fix lost and regained, then lost until the limit is just passed.
    queue_update(make_update(PIN_HOLD, 1'b0, 32'd70000, 10'd700));
    queue_update(make_update(PIN_HOLD, 1'b1, 32'd70001, 10'd600));
    queue_update(make_update(PIN_HOLD, 1'b0, 32'd80000, 10'd1022));
    queue_update(make_update(PIN_HOLD, 1'b0, 32'd110000, 10'd1));
    queue_update(make_update(PIN_HOLD, 1'b0, 32'd110001, 10'd540));
    // Back in no fix, the preheat is measured from the fix-lost stamp.
    queue_update(make_update(PIN_HOLD, 1'b1, 32'd139999, 10'd550));
    queue_update(make_update(PIN_HOLD, 1'b1, 32'd140000, 10'd800));
    // Sleep wins over a present fix while tracking.
    queue_update(make_update(PIN_SLEEP, 1'b1, 32'd140001, 10'd512));
    // Preheat across the wrap of the millisecond counter.
    queue_update(make_update(PIN_TRACK, 1'b0, 32'hFFFF_FFF0, 10'd256));
    queue_update(make_update(PIN_HOLD, 1'b1, 32'h0000_EA4F, 10'd640));
    queue_update(make_update(PIN_HOLD, 1'b1, 32'h0000_EA50, 10'd641));
    // Switch change while tracking, loss of fix, then sleep from fix lost.
    queue_update(make_update(PIN_LIGHT, 1'b0, 32'h0000_F000, 10'd900));
    queue_update(make_update(PIN_SLEEP, 1'b0, 32'h0000_F001, 10'd100));
    // Sleep wins over an expired preheat in no fix.
    queue_update(make_update(PIN_LIGHT, 1'b0, 32'h0001_0000, 10'd1000));
    queue_update(make_update(PIN_SLEEP, 1'b1, 32'h0003_0000, 10'd1023));
    time_cursor = 32'h0003_0000;
    wait_for_drain();

    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: begin
          preheat_value = 32'd0;
          limit_value = 32'd0;
          start_value = 32'h0000_FFFF;
        end
        1: begin
          preheat_value = 32'h00FF_FFFF;
          limit_value = 32'h00FF_FFFF;
          start_value = $urandom;
        end
        default: begin
          preheat_value = $urandom_range(0, 500) | ($urandom & 32'hFF00_0000);
          limit_value = $urandom_range(0, 500) | ($urandom & 32'hFF00_0000);
          start_value = $urandom;
        end
      endcase
      write_register(REG_PREHEAT, preheat_value);
      write_register(REG_FIX_LOST, limit_value);
      write_register(REG_START_TN, start_value);
      if (phase == 2) write_register(REG_SPARE, $urandom);

      // Time steps scale with the timeouts so that both get crossed.
      step_max = ((preheat_q > lost_limit_q) ? preheat_q : lost_limit_q) / 8 + 64;
      for (k = 0; k < ITEMS_PER_PHASE; k++) queue_update(random_update());
      wait_for_drain();
    end

    repeat (10) @(posedge clk);
    if (expected_results.size() != 0) error_count++;
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tmc_pkg.sv
rtl/tmc_cfg_regs.sv
rtl/tmc_mode_core.sv
rtl/tmc_battery.sv
rtl/tracker_mode_controller_unit.sv
verif/tracker_mode_controller_unit_test.sv
